[sv/frame_receive_patch_xor_check_macros.svh]
// assertion macros for the frame receiver
`ifndef FRAME_RECEIVE_PATCH_XOR_CHECK_MACROS_SVH
`define FRAME_RECEIVE_PATCH_XOR_CHECK_MACROS_SVH

`ifndef SYNTHESIS
// condition holds at every clock edge out of reset
`define FRPX_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define FRPX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FRPX_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define FRPX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[sv/frpx_pkg.sv]
package frpx_pkg;

    localparam int FRAME_LEN = 12;
    localparam int IDX_W     = 4;
    localparam int CHK_POS   = 6;
    localparam int TEMP_POS  = 9;

    localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_CHK   = IDX_W'(CHK_POS);
    localparam logic [IDX_W-1:0] IDX_TEMP  = IDX_W'(TEMP_POS);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] IDX_FULL  = IDX_W'(FRAME_LEN);

    localparam logic [7:0] TEMP_MAX = 8'h7F;
    localparam logic [7:0] GAP_MAX  = 8'hFF;

    // reset values of the registers
    localparam logic [7:0] START_BYTE_RST = 8'h41;
    localparam logic [7:0] GAP_LIMIT_RST  = 8'd50;
    localparam logic [7:0] TEMP_OFFS_RST  = 8'd15;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_START_BYTE = 2'd0,
        REG_GAP_LIMIT  = 2'd1,
        REG_TEMP_OFFS  = 2'd2,
        REG_NONE       = 2'd3
    } reg_idx_t;

    // input item kinds
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef enum logic {
        ST_RECV = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

    // where an emitted byte comes from
    typedef enum logic [1:0] {
        SRC_MEM  = 2'd0,
        SRC_CHK  = 2'd1,
        SRC_TEMP = 2'd2,
        SRC_NONE = 2'd3
    } src_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } wr_req_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } rd_req_t;

endpackage

[sv/frpx_store.sv]
module frpx_store
    import frpx_pkg::*;
(
    input  logic       clk,
    input  wr_req_t    wr,
    input  rd_req_t    rd,
    output logic [7:0] rd_data
);

    logic [7:0] mem [FRAME_LEN];
    logic [7:0] rd_data_reg;

    // byte write
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read with enable, data held while stalled
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/frame_receive_patch_xor_check.sv]
// a completed frame sets the emit state; byte 0 is then read into the output register
// throughput: one item per cycle while receiving; a completed frame then streams
// 12 items from the single read port of the frame store, input stalled, at one per
// cycle while the sink is ready; ticks and dropped bytes give no item
// reset: asynchronous, active low; counters and settings to defaults, store not cleared
module frame_receive_patch_xor_check
    import frpx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] rx_byte, [15:8] motor_temp
    input  logic        s_axis_tuser,   // [0] opcode
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tuser,   // [0] frame_ok
    output logic        m_axis_tlast
);

    state_t           state_reg, state_next;
    logic [7:0]       start_reg, gap_limit_reg, temp_offs_reg;
    logic [IDX_W-1:0] fill_reg, fill_next;
    logic [7:0]       gap_reg, gap_next;
    logic [7:0]       acc_reg, acc_next;
    logic [7:0]       b6_reg, b9_reg;
    logic [7:0]       chk_new_reg, t9_new_reg;
    logic             ok_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             out_valid_reg, out_last_reg, out_ok_reg;
    src_t             out_src_reg, src_sel;

    logic             in_acc, is_tick, store, complete, load;
    logic [7:0]       rx_byte, motor_temp;
    logic [IDX_W-1:0] eff_fill;
    logic [7:0]       temp_diff;
    logic             patch;
    logic [7:0]       t_sat;
    logic [7:0]       rd_data;
    wr_req_t          wr;
    rd_req_t          rd;

    assign rx_byte    = s_axis_tdata[7:0];
    assign motor_temp = s_axis_tdata[15:8];
    assign is_tick    = (s_axis_tuser == OP_TICK);
    assign in_acc     = s_axis_tvalid && s_axis_tready;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= START_BYTE_RST;
            gap_limit_reg <= GAP_LIMIT_RST;
            temp_offs_reg <= TEMP_OFFS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_START_BYTE: start_reg     <= cfg_data;
                REG_GAP_LIMIT:  gap_limit_reg <= cfg_data;
                REG_TEMP_OFFS:  temp_offs_reg <= cfg_data;
                REG_NONE:       ;
            endcase
        end
    end

    // receive decision
    assign eff_fill = (gap_reg > gap_limit_reg) ? IDX_FIRST : fill_reg;
    assign store    = in_acc && !is_tick && (eff_fill < IDX_FULL)
                      && !((eff_fill == IDX_FIRST) && (rx_byte != start_reg));
    assign complete = store && (eff_fill == IDX_LAST);

    // fill index, gap counter and running checksum
    always_comb
    begin
        fill_next = fill_reg;
        gap_next  = gap_reg;
        acc_next  = acc_reg;
        if (in_acc && is_tick)
        begin
            if (gap_reg != GAP_MAX)
            begin
                gap_next = gap_reg + 8'd1;
            end
        end
        else if (in_acc)
        begin
            fill_next = eff_fill;
            if (store)
            begin
                fill_next = eff_fill + IDX_W'(1);
                gap_next  = 8'd0;
                if (eff_fill == IDX_FIRST)
                begin
                    acc_next = 8'd0;
                end
                else if (eff_fill != IDX_CHK)
                begin
                    acc_next = acc_reg ^ rx_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= IDX_FIRST;
            gap_reg  <= 8'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            gap_reg  <= gap_next;
        end
    end

    // temperature patch value
    assign temp_diff = motor_temp - temp_offs_reg;
    assign patch     = motor_temp > temp_offs_reg;
    assign t_sat     = (temp_diff > TEMP_MAX) ? TEMP_MAX : temp_diff;

    // frame payload: checksum byte, temperature byte, result of the check
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (store && (eff_fill == IDX_CHK))
        begin
            b6_reg <= rx_byte;
        end
        if (store && (eff_fill == IDX_TEMP))
        begin
            b9_reg <= rx_byte;
        end
        if (complete)
        begin
            ok_reg <= (b6_reg == acc_next);
            if (patch)
            begin
                t9_new_reg  <= t_sat;
                chk_new_reg <= acc_next ^ b9_reg ^ t_sat;
            end
            else
            begin
                t9_new_reg  <= b9_reg;
                chk_new_reg <= b6_reg;
            end
        end
    end

    // frame store
    assign load = (state_reg == ST_EMIT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        wr.en   = store;
        wr.addr = eff_fill;
        wr.data = rx_byte;
        rd.en   = load;
        rd.addr = rd_idx_reg;
    end

    frpx_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    // state machine: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RECV:
            begin
                if (complete)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load && (rd_idx_reg == IDX_LAST))
                begin
                    state_next = ST_RECV;
                end
            end
        endcase
    end

    // state machine: outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_RECV: s_axis_tready = 1'b1;
            ST_EMIT: s_axis_tready = 1'b0;
        endcase
    end

    // byte source for the read in flight
    always_comb
    begin
        priority if (rd_idx_reg == IDX_CHK)
        begin
            src_sel = SRC_CHK;
        end
        else if (rd_idx_reg == IDX_TEMP)
        begin
            src_sel = SRC_TEMP;
        end
        else
        begin
            src_sel = SRC_MEM;
        end
    end

    // read sequencer and output register
    // check flag travels with each item so a waiting last item keeps it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RECV;
            rd_idx_reg    <= IDX_FIRST;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_src_reg   <= SRC_MEM;
        end
        else
        begin
            state_reg <= state_next;
            if (complete)
            begin
                rd_idx_reg <= IDX_FIRST;
            end
            else if (load)
            begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= (rd_idx_reg == IDX_LAST);
                out_ok_reg    <= ok_reg;
                out_src_reg   <= src_sel;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output byte selection
    always_comb
    begin
        unique case (out_src_reg)
            SRC_CHK:  m_axis_tdata = chk_new_reg;
            SRC_TEMP: m_axis_tdata = t9_new_reg;
            SRC_MEM:  m_axis_tdata = rd_data;
            default:  m_axis_tdata = rd_data;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_ok_reg;
    assign m_axis_tlast  = out_last_reg;

    // checks
    `include "frame_receive_patch_xor_check_macros.svh"

    `FRPX_ASSERT_ALWAYS(a_fill_range, clk, rst_n, fill_reg <= IDX_FULL)
    `FRPX_ASSERT_ALWAYS(a_emit_full, clk, rst_n, (state_reg != ST_EMIT) || (fill_reg == IDX_FULL))
    `FRPX_ASSERT_NEXT(a_emit_end, clk, rst_n,
        (state_reg == ST_EMIT) && load && (rd_idx_reg == IDX_LAST),
        (state_reg == ST_RECV) && m_axis_tvalid && m_axis_tlast)

endmodule

[tb/frame_receive_patch_xor_check_tb.sv]
module frame_receive_patch_xor_check_tb
    import frpx_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_ITEMS   = 90;

    // one input item and one emitted frame byte
    typedef struct packed {
        opcode_t    op;
        logic [7:0] rx;
        logic [7:0] temp;
    } rx_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       ok;
        logic       last;
    } frame_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_START_BYTE;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'h0000;   // [7:0] rx_byte, [15:8] motor_temp
    logic        s_axis_tuser = OP_BYTE;    // [0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;              // [7:0] out_byte
    logic        m_axis_tuser;              // [0] frame_ok
    logic        m_axis_tlast;

    frame_receive_patch_xor_check dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    rx_item_t    pending[$];
    frame_byte_t due_bytes[$];

    // receiver state as the block should hold it
    logic [7:0] want_start = START_BYTE_RST;
    logic [7:0] gap_limit  = GAP_LIMIT_RST;
    logic [7:0] temp_offs  = TEMP_OFFS_RST;
    logic [7:0] frame_mem[FRAME_LEN];
    logic [3:0] fill_pos = '0;
    logic [7:0] idle_ms  = '0;

    int   src_idle = 0;
    int   sink_idle = 0;
    logic in_taken = 1'b0;
    int   errors = 0;
    int   n_items = 0;
    int   n_ticks = 0;
    int   n_frames = 0;
    int   n_checked = 0;
    int   n_cfg = 0;
    int   stall_cycles = 0;
    int   rand_items = 0;

    // xor of bytes 1..11 without the checksum byte
    function automatic logic [7:0] frame_xor();
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 1; k < FRAME_LEN; k++)
            if (k != CHK_POS)
                acc ^= frame_mem[k];
        return acc;
    endfunction

    // advance the receiver by one accepted item, queue any frame it completes
    function automatic void frame_step(rx_item_t it);
        logic        ok;
        logic [8:0]  t;
        frame_byte_t fb;
        if (it.op == OP_TICK)
        begin
            if (idle_ms != GAP_MAX)
                idle_ms++;
            n_ticks++;
            return;
        end
        if (idle_ms > gap_limit)
            fill_pos = '0;
        if (fill_pos == IDX_FIRST && it.rx != want_start)
            return;
        if (fill_pos >= IDX_FULL)
            return;
        frame_mem[fill_pos] = it.rx;
        fill_pos++;
        idle_ms = '0;
        if (fill_pos != IDX_FULL)
            return;
        ok = (frame_mem[CHK_POS] == frame_xor());
        if (it.temp > temp_offs)
        begin
            t = {1'b0, it.temp} - {1'b0, temp_offs};
            if (t > {1'b0, TEMP_MAX})
                t = {1'b0, TEMP_MAX};
            frame_mem[TEMP_POS] = t[7:0];
            frame_mem[CHK_POS] = frame_xor();
        end
        for (int k = 0; k < FRAME_LEN; k++)
        begin
            fb.data = frame_mem[k];
            fb.ok   = ok;
            fb.last = (k == FRAME_LEN - 1);
            due_bytes.push_back(fb);
        end
        n_frames++;
    endfunction

    // input side: drive at the falling edge
    always @(negedge clk)
    begin : drive_in
        rx_item_t it;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_taken)
        begin
            if (pending.size() != 0 && $urandom_range(99) >= src_idle)
            begin
                it = pending.pop_front();
                s_axis_tdata  <= {it.temp, it.rx};
                s_axis_tuser  <= it.op;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // output side back-pressure
    always @(negedge clk)
        m_axis_tready <= rst_n && ($urandom_range(99) >= sink_idle);

    // accepted input items and register writes feed the prediction
    always @(posedge clk)
    begin : watch_in
        rx_item_t it;
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            it.op   = opcode_t'(s_axis_tuser);
            it.rx   = s_axis_tdata[7:0];
            it.temp = s_axis_tdata[15:8];
            frame_step(it);
            n_items++;
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_START_BYTE: want_start = cfg_data;
                REG_GAP_LIMIT:  gap_limit  = cfg_data;
                REG_TEMP_OFFS:  temp_offs  = cfg_data;
                default: ;
            endcase
            n_cfg++;
        end
    end

    // emitted frame bytes against the oldest expectation
    always @(posedge clk)
    begin : watch_out
        frame_byte_t fb;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_bytes.size() == 0)
            begin
                $display("%0t: unexpected item: out_byte %02h frame_ok %0b last %0b",
                         $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end
            else
            begin
                fb = due_bytes.pop_front();
                if (m_axis_tdata !== fb.data)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $realtime, fb.data, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== fb.ok)
                begin
                    $display("%0t: frame_ok expected %0b actual %0b",
                             $realtime, fb.ok, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== fb.last)
                begin
                    $display("%0t: last expected %0b actual %0b",
                             $realtime, fb.last, m_axis_tlast);
                    errors++;
                end
                n_checked++;
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else if (stall_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d frame bytes outstanding",
                         $realtime, WATCHDOG_LIMIT, due_bytes.size());
                $display("frame_receive_patch_xor_check_tb: done, errors");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic void push_item(opcode_t op, logic [7:0] rx, logic [7:0] temp);
        rx_item_t it;
        it.op   = op;
        it.rx   = rx;
        it.temp = temp;
        pending.push_back(it);
        rand_items++;
    endfunction

    function automatic void push_ticks(int n);
        for (int k = 0; k < n; k++)
            push_item(OP_TICK, 8'($urandom), 8'($urandom));
    endfunction

    // temperatures around the offset, at the top, or anywhere
    function automatic logic [7:0] pick_temp();
        case ($urandom_range(2))
            0:       return temp_offs + 8'($urandom_range(3));
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // a complete frame, up to tick_max ticks between bytes, temp on the last byte
    function automatic void queue_frame(logic [7:0] start, bit bad_chk, logic [7:0] temp,
                                        int tick_max);
        logic [7:0] fb[FRAME_LEN];
        fb[0] = start;
        for (int k = 1; k < FRAME_LEN; k++)
            fb[k] = 8'($urandom);
        fb[CHK_POS] = 8'h00;
        for (int k = 1; k < FRAME_LEN; k++)
            fb[CHK_POS] ^= (k == CHK_POS) ? 8'h00 : fb[k];
        if (bad_chk)
            fb[CHK_POS] ^= 8'(1 << $urandom_range(7));
        for (int k = 0; k < FRAME_LEN; k++)
        begin
            if (k != 0)
                push_ticks($urandom_range(tick_max));
            push_item(OP_BYTE, fb[k], (k == FRAME_LEN - 1) ? temp : 8'($urandom));
        end
    endfunction

    task automatic write_reg(reg_idx_t idx, logic [7:0] value);
        int seen;
        seen = n_cfg;
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        wait (n_cfg != seen);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // let the stream run dry and the block settle
    task automatic drain();
        while (pending.size() != 0 || s_axis_tvalid || due_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] b;
        int         lim;
        int         phase_items;
        int         r;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        src_idle  = 15;
        sink_idle = 81;

        // reset settings: wrong start, saturated patch, byte after a full frame
        push_item(OP_BYTE, 8'h00, 8'h00);
        push_ticks(1);
        queue_frame(START_BYTE_RST, 1'b0, 8'hFF, 0);
        push_item(OP_BYTE, START_BYTE_RST, 8'hFF);
        drain();

        // zero gap limit: any tick restarts; offset 0 patches from temperature 1
        write_reg(REG_START_BYTE, 8'hFF);
        write_reg(REG_GAP_LIMIT, 8'h00);
        write_reg(REG_TEMP_OFFS, 8'h00);
        push_ticks(1);
        push_item(OP_BYTE, 8'hFF, 8'h00);
        push_item(OP_BYTE, 8'h12, 8'h00);
        push_ticks(1);
        push_item(OP_BYTE, 8'h7E, 8'h00);
        queue_frame(8'hFF, 1'b1, 8'h00, 0);
        push_ticks(1);
        queue_frame(8'hFF, 1'b0, 8'h01, 0);
        drain();

        // limit 255 never restarts a completed frame; top offset never patches
        write_reg(REG_START_BYTE, 8'h00);
        write_reg(REG_GAP_LIMIT, 8'hFF);
        write_reg(REG_TEMP_OFFS, 8'hFF);
        push_ticks(2);
        queue_frame(8'h00, 1'b0, 8'hFF, 3);
        push_ticks(3);
        push_item(OP_BYTE, 8'h00, 8'hFF);
        drain();

        // idle count saturates at 255, just beyond a limit of 254
        write_reg(REG_GAP_LIMIT, 8'd254);
        push_ticks(256);
        queue_frame(8'h00, 1'b0, 8'h80, 2);
        drain();

        // random settings, mostly well-formed frames with random content
        // one batch per idle pattern: slow receiver, slow sender, no idling
        rand_items = 0;
        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle  = (ph == 0) ? 15 : ((ph == 1) ? 81 : 0);
            sink_idle = (ph == 0) ? 81 : ((ph == 1) ? 15 : 0);
            write_reg(REG_START_BYTE, 8'($urandom));
            write_reg(REG_GAP_LIMIT, ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(1, 6)));
            write_reg(REG_TEMP_OFFS, ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom));
            lim = gap_limit;
            phase_items = rand_items;
            while (rand_items - phase_items < RANDOM_ITEMS / 3)
            begin
                r = $urandom_range(99);
                if (r < 70)
                begin
                    queue_frame(want_start, $urandom_range(3) == 0, pick_temp(), lim);
                    if ($urandom_range(3) == 0)
                        push_item(OP_BYTE, want_start, 8'($urandom));
                end
                else if (r < 85)
                begin
                    // truncated frame, or a wrong start byte
                    if ($urandom_range(1) == 0)
                    begin
                        push_item(OP_BYTE, want_start, 8'($urandom));
                        for (int k = $urandom_range(10); k > 0; k--)
                            push_item(OP_BYTE, 8'($urandom), 8'($urandom));
                    end
                    else
                    begin
                        b = want_start ^ 8'($urandom_range(1, 255));
                        push_item(OP_BYTE, b, pick_temp());
                    end
                end
                else
                begin
                    for (int k = $urandom_range(1, 4); k > 0; k--)
                        push_item(opcode_t'($urandom_range(1)), 8'($urandom), 8'($urandom));
                end
                // idle long enough to restart reception
                push_ticks(lim + 1);
            end
            drain();
        end

        $display("covered %0d input items (%0d ticks), %0d frames emitted, %0d register writes",
                 n_items, n_ticks, n_frames, n_cfg);
        $display("checked %0d output items against the prediction", n_checked);
        if (errors == 0)
            $display("frame_receive_patch_xor_check_tb: done, clean");
        else
            $display("frame_receive_patch_xor_check_tb: done, errors");
        $finish;
    end

endmodule
